FILE: rtl/ajrb_pkg.sv
// Shared constants, types and helpers for the audio jitter ring buffer.
// No dependencies; used by every module under rtl/.
package ajrb_pkg;

    localparam int DEPTH     = 131072;
    localparam int MAX_FRAME = 4096;

    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int PTR_W       = $clog2(DEPTH + 1);
    localparam int SAMPLE_W    = 8;
    localparam int FRAME_LEN_W = 13;
    localparam int BUF_LEN_W   = 18;
    localparam int PREBUF_W    = 18;
    localparam int RSTART_W    = 17;
    localparam int FILL_W      = 18;
    localparam int KIND_W      = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 18;

    localparam int RP_W   = (PTR_W > RSTART_W) ? PTR_W : RSTART_W;
    localparam int MAXA_W = (RP_W > FRAME_LEN_W) ? RP_W : FRAME_LEN_W;
    localparam int MAXB_W = (MAXA_W > PREBUF_W) ? MAXA_W : PREBUF_W;
    localparam int LVL_W  = MAXB_W + 2;

    localparam int LEVEL_MAX = (1 << FILL_W) - 1;

    localparam int IN_TDATA_W  = 24;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_TUSER_W = 2;

    localparam logic [BUF_LEN_W-1:0] RESET_BUFFER_LEN = BUF_LEN_W'(81920);
    localparam logic [PREBUF_W-1:0]  RESET_PREBUF     = PREBUF_W'(6400);
    localparam logic [RSTART_W-1:0]  RESET_READ_START = RSTART_W'(320);

    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LEN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PREBUF     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_READ_START = CFG_IDX_W'(2);

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_FLUSH = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DIFF,
        ST_LEVEL,
        ST_DECIDE,
        ST_RDATA,
        ST_CLEAR,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [PTR_W-1:0]       wp;
        logic [RP_W-1:0]        rp;
        logic [FRAME_LEN_W-1:0] flen;
        logic                   is_read;
        logic                   wrapped;
        logic [PTR_W-1:0]       len;
    } lvl_req_t;

    typedef struct packed {
        logic signed [LVL_W-1:0] lv;
        logic                    over;
    } lvl_rsp_t;

    typedef struct packed {
        logic                en;
        logic                we;
        logic [ADDR_W-1:0]   addr;
        logic [SAMPLE_W-1:0] wdata;
    } ram_req_t;

    // 0 acts as 1, anything above the store size acts as the store size
    function automatic logic [PTR_W-1:0] eff_len(input logic [BUF_LEN_W-1:0] v);
        logic [PTR_W-1:0] r;
        if (v == '0)
            r = PTR_W'(1);
        else if (32'(v) > 32'(DEPTH))
            r = PTR_W'(DEPTH);
        else
            r = PTR_W'(v);
        return r;
    endfunction

endpackage

FILE: rtl/audio_jitter_ring_buffer.sv
// Audio jitter ring buffer top level: control sequencer, config registers, output stage.
// Depends on ajrb_pkg, ajrb_ram and ajrb_level.
//
// Usage: words on s_axis carry write byte, read byte or flush (kind in tuser).
// Every input word yields exactly one output word on m_axis: the read byte
// (zero when muted), mute/drop flags in tuser, and the fill level computed at
// the last frame start. One word is processed at a time.
// From accept to output valid a write passes DECIDE and OUT, a read DECIDE,
// RDATA (skipped when muted) and OUT; with frame_start set, DIFF and LEVEL
// (level unit) come before DECIDE. An unused kind goes straight to OUT.
// The single RAM port and the sequencer allow no overlap: the next word is
// accepted in IDLE only after the current one has left OUT. Flush clears
// the whole store one byte a cycle and then produces its result in OUT.
// After reset the same clearing pass runs over the whole store before
// s_axis_tready first rises; config writes are taken during it.
// A stalled receiver holds the output word; the next input word is still
// accepted and processed, and its result waits until the output register
// frees up.
module audio_jitter_ring_buffer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // sample_in[7:0], frame_start[8], frame_len[21:9], zero pad
    input  logic [ajrb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // kind[1:0]
    input  logic [ajrb_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // data_out[7:0], fill_level[25:8], zero pad
    output logic [ajrb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // was_muted[0], was_dropped[1]
    output logic [ajrb_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,
    input  logic                                cfg_we,
    input  logic [ajrb_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [ajrb_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int LW = ajrb_pkg::LVL_W;

    ajrb_pkg::state_t state_reg, state_next;

    // item payload
    ajrb_pkg::kind_t                       kind_reg, kind_next;
    logic [ajrb_pkg::SAMPLE_W-1:0]         sample_reg, sample_next;
    logic                                  fs_reg, fs_next;
    logic [ajrb_pkg::FRAME_LEN_W-1:0]      flen_reg, flen_next;

    // config
    logic [ajrb_pkg::PTR_W-1:0]            len_reg, len_next;
    logic [ajrb_pkg::PREBUF_W-1:0]         prebuf_reg, prebuf_next;
    logic [ajrb_pkg::RSTART_W-1:0]         rstart_reg, rstart_next;

    // run state
    logic [ajrb_pkg::PTR_W-1:0]            wp_reg, wp_next;
    logic [ajrb_pkg::RP_W-1:0]             rp_reg, rp_next;
    logic                                  wrapped_reg, wrapped_next;
    logic                                  dropping_reg, dropping_next;
    logic                                  toggle_reg, toggle_next;
    logic                                  refill_reg, refill_next;
    logic                                  mode_drop_reg, mode_drop_next;
    logic                                  mode_silent_reg, mode_silent_next;
    logic [ajrb_pkg::FILL_W-1:0]           fill_reg, fill_next;
    logic [ajrb_pkg::ADDR_W-1:0]           clr_cnt_reg, clr_cnt_next;

    // result and output stage
    logic [ajrb_pkg::SAMPLE_W-1:0]         res_data_reg, res_data_next;
    logic                                  res_muted_reg, res_muted_next;
    logic                                  res_dropped_reg, res_dropped_next;
    logic [ajrb_pkg::SAMPLE_W-1:0]         out_data_reg, out_data_next;
    logic                                  out_muted_reg, out_muted_next;
    logic                                  out_dropped_reg, out_dropped_next;
    logic [ajrb_pkg::FILL_W-1:0]           out_fill_reg, out_fill_next;
    logic                                  out_valid_reg, out_valid_next;

    logic                                  s_accept;
    logic                                  m_accept;
    logic [ajrb_pkg::FRAME_LEN_W-1:0]      flen_in;
    ajrb_pkg::ram_req_t                    ram_req;
    logic [ajrb_pkg::SAMPLE_W-1:0]         ram_rdata;
    ajrb_pkg::lvl_req_t                    lvl_req;
    ajrb_pkg::lvl_rsp_t                    lvl_rsp;

    logic signed [LW-1:0]                  lv;
    logic signed [LW-1:0]                  half_s;
    logic signed [LW-1:0]                  prebuf_s;
    logic [ajrb_pkg::FILL_W-1:0]           lv_sat;
    logic                                  drop;
    logic                                  silent;
    logic                                  wrap;
    logic [ajrb_pkg::ADDR_W-1:0]           acc_addr;

    ajrb_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    ajrb_level u_level (
        .clk (clk),
        .req (lvl_req),
        .rsp (lvl_rsp)
    );

    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign m_accept = out_valid_reg && m_axis_tready;
    assign flen_in  = (32'(s_axis_tdata[21:9]) > 32'(ajrb_pkg::MAX_FRAME)) ?
                      ajrb_pkg::FRAME_LEN_W'(ajrb_pkg::MAX_FRAME) : s_axis_tdata[21:9];

    always_comb
    begin
        lvl_req.wp      = wp_reg;
        lvl_req.rp      = rp_reg;
        lvl_req.flen    = flen_reg;
        lvl_req.is_read = (kind_reg == ajrb_pkg::KIND_READ);
        lvl_req.wrapped = wrapped_reg;
        lvl_req.len     = len_reg;
    end

    always_comb
    begin
        lv       = lvl_rsp.lv;
        half_s   = signed'(LW'(prebuf_reg >> 1));
        prebuf_s = signed'(LW'(prebuf_reg));
        if (lv < 0)
            lv_sat = '0;
        else if (lv > signed'(LW'(ajrb_pkg::LEVEL_MAX)))
            lv_sat = ajrb_pkg::FILL_W'(ajrb_pkg::LEVEL_MAX);
        else
            lv_sat = lv[ajrb_pkg::FILL_W-1:0];
    end

    always_comb
    begin
        state_next       = state_reg;
        kind_next        = kind_reg;
        sample_next      = sample_reg;
        fs_next          = fs_reg;
        flen_next        = flen_reg;
        len_next         = len_reg;
        prebuf_next      = prebuf_reg;
        rstart_next      = rstart_reg;
        wp_next          = wp_reg;
        rp_next          = rp_reg;
        wrapped_next     = wrapped_reg;
        dropping_next    = dropping_reg;
        toggle_next      = toggle_reg;
        refill_next      = refill_reg;
        mode_drop_next   = mode_drop_reg;
        mode_silent_next = mode_silent_reg;
        fill_next        = fill_reg;
        clr_cnt_next     = clr_cnt_reg;
        res_data_next    = res_data_reg;
        res_muted_next   = res_muted_reg;
        res_dropped_next = res_dropped_reg;
        out_data_next    = out_data_reg;
        out_muted_next   = out_muted_reg;
        out_dropped_next = out_dropped_reg;
        out_fill_next    = out_fill_reg;
        out_valid_next   = out_valid_reg;
        ram_req.en       = 1'b0;
        ram_req.we       = 1'b0;
        ram_req.addr     = clr_cnt_reg;
        ram_req.wdata    = '0;
        drop             = mode_drop_reg;
        silent           = mode_silent_reg;
        wrap             = 1'b0;
        acc_addr         = '0;

        if (cfg_we)
        begin
            unique case (cfg_addr)
                ajrb_pkg::CFG_BUFFER_LEN: len_next    = ajrb_pkg::eff_len(cfg_wdata);
                ajrb_pkg::CFG_PREBUF:     prebuf_next = cfg_wdata;
                ajrb_pkg::CFG_READ_START: rstart_next = cfg_wdata[ajrb_pkg::RSTART_W-1:0];
                default: ;
            endcase
        end

        if (m_accept)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ajrb_pkg::ST_INIT, ajrb_pkg::ST_CLEAR:
            begin
                ram_req.en = 1'b1;
                ram_req.we = 1'b1;
                if (clr_cnt_reg == ajrb_pkg::ADDR_W'(ajrb_pkg::DEPTH - 1))
                begin
                    clr_cnt_next = '0;
                    state_next   = (state_reg == ajrb_pkg::ST_INIT) ?
                                   ajrb_pkg::ST_IDLE : ajrb_pkg::ST_OUT;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end

            ajrb_pkg::ST_IDLE:
            begin
                if (s_accept)
                begin
                    kind_next        = ajrb_pkg::kind_t'(s_axis_tuser[ajrb_pkg::KIND_W-1:0]);
                    sample_next      = s_axis_tdata[7:0];
                    fs_next          = s_axis_tdata[8];
                    flen_next        = flen_in;
                    res_data_next    = '0;
                    res_muted_next   = 1'b0;
                    res_dropped_next = 1'b0;
                    unique case (ajrb_pkg::kind_t'(s_axis_tuser[ajrb_pkg::KIND_W-1:0]))
                        ajrb_pkg::KIND_WRITE, ajrb_pkg::KIND_READ:
                            state_next = s_axis_tdata[8] ? ajrb_pkg::ST_DIFF :
                                                           ajrb_pkg::ST_DECIDE;
                        ajrb_pkg::KIND_FLUSH:
                        begin
                            wp_next          = '0;
                            rp_next          = ajrb_pkg::RP_W'(rstart_reg);
                            wrapped_next     = 1'b0;
                            dropping_next    = 1'b0;
                            toggle_next      = 1'b0;
                            refill_next      = 1'b0;
                            mode_drop_next   = 1'b0;
                            mode_silent_next = 1'b0;
                            clr_cnt_next     = '0;
                            state_next       = ajrb_pkg::ST_CLEAR;
                        end
                        default:
                            state_next = ajrb_pkg::ST_OUT;
                    endcase
                end
            end

            ajrb_pkg::ST_DIFF:
                state_next = ajrb_pkg::ST_LEVEL;

            ajrb_pkg::ST_LEVEL:
                state_next = ajrb_pkg::ST_DECIDE;

            ajrb_pkg::ST_DECIDE:
            begin
                if (kind_reg == ajrb_pkg::KIND_WRITE)
                begin
                    if (fs_reg)
                    begin
                        fill_next = lv_sat;
                        drop      = 1'b0;
                        if (dropping_reg)
                        begin
                            toggle_next = !toggle_reg;
                            drop        = toggle_reg;
                            if (lv <= half_s)
                                dropping_next = 1'b0;
                        end
                        else if (lv >= prebuf_s)
                        begin
                            dropping_next = 1'b1;
                        end
                        mode_drop_next = drop;
                    end
                    if (drop)
                    begin
                        res_dropped_next = 1'b1;
                    end
                    else
                    begin
                        wrap       = wp_reg >= len_reg;
                        acc_addr   = wrap ? '0 : wp_reg[ajrb_pkg::ADDR_W-1:0];
                        if (wrap)
                            wrapped_next = 1'b1;
                        wp_next       = ajrb_pkg::PTR_W'(acc_addr) + 1'b1;
                        ram_req.en    = 1'b1;
                        ram_req.we    = 1'b1;
                        ram_req.addr  = acc_addr;
                        ram_req.wdata = sample_reg;
                    end
                    state_next = ajrb_pkg::ST_OUT;
                end
                else
                begin
                    if (fs_reg)
                    begin
                        fill_next = lv_sat;
                        silent    = 1'b0;
                        if (refill_reg)
                        begin
                            if (lv < half_s)
                                silent = 1'b1;
                            else
                                refill_next = 1'b0;
                        end
                        if (!silent && lv <= 0)
                        begin
                            refill_next = 1'b1;
                            silent      = 1'b1;
                        end
                        if (!silent && lvl_rsp.over && !wrapped_reg)
                            silent = 1'b1;
                        mode_silent_next = silent;
                    end
                    if (silent)
                    begin
                        res_muted_next = 1'b1;
                        state_next     = ajrb_pkg::ST_OUT;
                    end
                    else
                    begin
                        wrap     = rp_reg >= ajrb_pkg::RP_W'(len_reg);
                        acc_addr = wrap ? '0 : rp_reg[ajrb_pkg::ADDR_W-1:0];
                        if (wrap)
                            wrapped_next = 1'b0;
                        rp_next       = ajrb_pkg::RP_W'(acc_addr) + 1'b1;
                        ram_req.en    = 1'b1;
                        ram_req.we    = 1'b1;
                        ram_req.addr  = acc_addr;
                        ram_req.wdata = '0;
                        state_next    = ajrb_pkg::ST_RDATA;
                    end
                end
            end

            ajrb_pkg::ST_RDATA:
            begin
                res_data_next = ram_rdata;
                state_next    = ajrb_pkg::ST_OUT;
            end

            ajrb_pkg::ST_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_data_next    = res_data_reg;
                    out_muted_next   = res_muted_reg;
                    out_dropped_next = res_dropped_reg;
                    out_fill_next    = fill_reg;
                    out_valid_next   = 1'b1;
                    state_next       = ajrb_pkg::ST_IDLE;
                end
            end

            default:
                state_next = ajrb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ajrb_pkg::ST_INIT;
            len_reg         <= ajrb_pkg::eff_len(ajrb_pkg::RESET_BUFFER_LEN);
            prebuf_reg      <= ajrb_pkg::RESET_PREBUF;
            rstart_reg      <= ajrb_pkg::RESET_READ_START;
            wp_reg          <= '0;
            rp_reg          <= ajrb_pkg::RP_W'(ajrb_pkg::RESET_READ_START);
            wrapped_reg     <= 1'b0;
            dropping_reg    <= 1'b0;
            toggle_reg      <= 1'b0;
            refill_reg      <= 1'b0;
            mode_drop_reg   <= 1'b0;
            mode_silent_reg <= 1'b0;
            fill_reg        <= '0;
            clr_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            len_reg         <= len_next;
            prebuf_reg      <= prebuf_next;
            rstart_reg      <= rstart_next;
            wp_reg          <= wp_next;
            rp_reg          <= rp_next;
            wrapped_reg     <= wrapped_next;
            dropping_reg    <= dropping_next;
            toggle_reg      <= toggle_next;
            refill_reg      <= refill_next;
            mode_drop_reg   <= mode_drop_next;
            mode_silent_reg <= mode_silent_next;
            fill_reg        <= fill_next;
            clr_cnt_reg     <= clr_cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        sample_reg      <= sample_next;
        fs_reg          <= fs_next;
        flen_reg        <= flen_next;
        res_data_reg    <= res_data_next;
        res_muted_reg   <= res_muted_next;
        res_dropped_reg <= res_dropped_next;
        out_data_reg    <= out_data_next;
        out_muted_reg   <= out_muted_next;
        out_dropped_reg <= out_dropped_next;
        out_fill_reg    <= out_fill_next;
    end

    assign s_axis_tready = (state_reg == ajrb_pkg::ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = ajrb_pkg::OUT_TDATA_W'({out_fill_reg, out_data_reg});
    assign m_axis_tuser  = {out_dropped_reg, out_muted_reg};

    a_flush_resets: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && (s_axis_tuser == ajrb_pkg::KIND_FLUSH)
        |=> (wp_reg == '0) && !wrapped_reg && (state_reg == ajrb_pkg::ST_CLEAR))
        else $error("flush did not reset pointers or start the clear pass");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> !s_axis_tready)
        else $error("second word accepted while one is in flight");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("output word both muted and dropped");

endmodule

FILE: rtl/ajrb_ram.sv
// Single-port byte store, read-first, with a registered read port.
// Depends on ajrb_pkg for depth and width.
module ajrb_ram (
    input  logic                         clk,
    input  ajrb_pkg::ram_req_t           req,
    output logic [ajrb_pkg::SAMPLE_W-1:0] rdata
);

    logic [ajrb_pkg::SAMPLE_W-1:0] mem [ajrb_pkg::DEPTH];
    logic [ajrb_pkg::SAMPLE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.we)
                mem[req.addr] <= req.wdata;
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/ajrb_level.sv
// Two-stage fill level unit: pointer difference, then wrap correction.
// Depends on ajrb_pkg for the request and response structs.
module ajrb_level (
    input  logic               clk,
    input  ajrb_pkg::lvl_req_t req,
    output ajrb_pkg::lvl_rsp_t rsp
);

    localparam int LW = ajrb_pkg::LVL_W;

    logic [LW-1:0]        sum_u;
    logic [LW-1:0]        flen_used;
    logic signed [LW-1:0] diff_next;
    logic signed [LW-1:0] diff_reg;
    logic                 over_next;
    logic                 over_reg;
    logic                 wrapped_reg;
    logic [ajrb_pkg::PTR_W-1:0] len_reg;
    logic signed [LW-1:0] absd;
    logic signed [LW-1:0] lv_next;
    logic signed [LW-1:0] lv_reg;
    logic                 over2_reg;

    always_comb
    begin
        flen_used = req.is_read ? LW'(req.flen) : '0;
        sum_u     = LW'(req.rp) + LW'(req.flen);
        diff_next = signed'(LW'(req.wp) - (LW'(req.rp) + flen_used));
        over_next = sum_u > LW'(req.len);
    end

    always_ff @(posedge clk)
    begin
        diff_reg    <= diff_next;
        over_reg    <= over_next;
        wrapped_reg <= req.wrapped;
        len_reg     <= req.len;
    end

    always_comb
    begin
        absd    = (diff_reg < 0) ? -diff_reg : diff_reg;
        lv_next = wrapped_reg ? (signed'(LW'(len_reg)) - absd) : diff_reg;
    end

    always_ff @(posedge clk)
    begin
        lv_reg    <= lv_next;
        over2_reg <= over_reg;
    end

    assign rsp.lv   = lv_reg;
    assign rsp.over = over2_reg;

endmodule
